// File: src/ofa_pkg.sv
package ofa_pkg;

  // Sample and coefficient format, signed Q1.15
  localparam int unsigned SMP_W  = 16;
  localparam int unsigned COEF_W = 16;
  localparam int unsigned PROD_W = SMP_W + COEF_W;

  // Coefficient register file: four taps to each 64-bit register
  localparam int unsigned PACK_COUNT    = 8;
  localparam int unsigned TAPS_PER_PACK = 4;
  localparam int unsigned CFG_IDX_W     = $clog2(PACK_COUNT);
  localparam int unsigned CFG_DATA_W    = COEF_W * TAPS_PER_PACK;

  // Default filter order (taps are 0 .. order)
  localparam int unsigned DEF_FIR_ORDER = 31;

  // Rounding: half up at the shift by 15
  localparam int unsigned FRAC_BITS  = 15;
  localparam int unsigned ROUND_BIAS = 1 << (FRAC_BITS - 1);

endpackage

// File: src/overlap_add_fir_filter_core.sv
// Path from sample beat to result beat: a register in the tap cells, one per level of the
//   adder tree, and one for round and saturate.
// Throughput: one sample per cycle until a stalled output fills every stage; each stage moves
//   on its own, so bubbles close up under a stalled output.
// Reset clears the delay line, the coefficient registers and all stage valid bits.
module overlap_add_fir_filter_core
  import ofa_pkg::*;
#(
  parameter int unsigned FirOrder = DEF_FIR_ORDER
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // coefficient write port
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata_i,
  // sample input
  input  logic                     sample_in_valid_i,
  output logic                     sample_in_ready_o,
  input  logic signed [SMP_W-1:0]  sample_in_i,
  // result output
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [SMP_W-1:0]  filtered_out_o,
  output logic                     saturated_o
);

  localparam int unsigned NumTaps   = FirOrder + 1;
  localparam int unsigned Levels    = $clog2(NumTaps);
  localparam int unsigned NumLeaves = 1 << Levels;
  localparam int unsigned AccW      = PROD_W + Levels;
  localparam int unsigned Stages    = Levels + 2;
  localparam int unsigned OutStage  = Stages - 1;

  logic [CFG_DATA_W-1:0]    coeff_q [PACK_COUNT];
  logic signed [COEF_W-1:0] coef    [NumTaps];
  logic signed [SMP_W-1:0]  smp     [NumTaps+1];
  logic signed [PROD_W-1:0] leaf    [NumLeaves];
  logic signed [AccW-1:0]   sum;
  logic [Stages-1:0]        vld_q;
  logic [Stages-1:0]        adv;
  logic                     accept;

  // Coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < PACK_COUNT; r++) begin
        coeff_q[r] <= '0;
      end
    end else if (cfg_we_i) begin
      coeff_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // Stage advance: a stage moves when empty or when the one after it moves
  always_comb begin
    adv[OutStage] = !vld_q[OutStage] || out_ready_i;
    for (int s = OutStage - 1; s >= 0; s--) begin
      adv[s] = !vld_q[s] || adv[s+1];
    end
  end

  assign sample_in_ready_o = adv[0];
  assign accept            = sample_in_valid_i && adv[0];

  // Beat valid bits along the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= sample_in_valid_i;
      end
      for (int s = 1; s < Stages; s++) begin
        if (adv[s]) begin
          vld_q[s] <= vld_q[s-1];
        end
      end
    end
  end

  // Row of tap cells; the sample shifts right on each accepted beat
  assign smp[0] = sample_in_i;

  for (genvar k = 0; k < NumTaps; k++) begin : g_tap
    assign coef[k] = coeff_q[k / TAPS_PER_PACK][COEF_W * (k % TAPS_PER_PACK) +: COEF_W];

    ofa_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (accept),
      .smp_i   (smp[k]),
      .coef_i  (coef[k]),
      .smp_o   (smp[k+1]),
      .prod_o  (leaf[k])
    );
  end

  // Tree leaves past the last tap read as zero
  for (genvar k = NumTaps; k < NumLeaves; k++) begin : g_pad
    assign leaf[k] = '0;
  end

  ofa_add_tree #(
    .Levels (Levels)
  ) u_tree (
    .clk_i  (clk_i),
    .adv_i  (adv[Levels:1]),
    .leaf_i (leaf),
    .sum_o  (sum)
  );

  ofa_out_stage #(
    .AccW (AccW)
  ) u_out (
    .clk_i       (clk_i),
    .load_i      (adv[OutStage]),
    .sum_i       (sum),
    .filtered_o  (filtered_out_o),
    .saturated_o (saturated_o)
  );

  assign out_valid_o = vld_q[OutStage];

  // Input is refused only when every stage holds a beat
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sample_in_ready_o |-> (&vld_q))
    else $error("input stalled with a free pipeline stage");

  // An accepted sample lands in the first delay-line stage
  a_line_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (smp[1] == $past(sample_in_i)))
    else $error("delay line did not take the accepted sample");

  // A beat in the product stage moves into the tree when it advances
  a_tree_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[0] && adv[1]) |=> vld_q[1])
    else $error("beat lost between product stage and adder tree");

  // A clipped result sits at one of the range limits
  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |->
      (filtered_out_o == 16'sh7fff || filtered_out_o == -16'sh8000))
    else $error("saturated flag with an in-range value");

endmodule

// File: src/ofa_cell.sv
module ofa_cell
  import ofa_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     shift_i,
  input  logic signed [SMP_W-1:0]  smp_i,
  input  logic signed [COEF_W-1:0] coef_i,
  output logic signed [SMP_W-1:0]  smp_o,
  output logic signed [PROD_W-1:0] prod_o
);

  logic signed [SMP_W-1:0]  smp_q;
  logic signed [PROD_W-1:0] prod_d, prod_q;

  // Tap product for the sample arriving from the left neighbour
  assign prod_d = PROD_W'(smp_i) * PROD_W'(coef_i);

  // Delay-line stage, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_q <= '0;
    end else if (shift_i) begin
      smp_q <= smp_i;
    end
  end

  // Product register
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      prod_q <= prod_d;
    end
  end

  assign smp_o  = smp_q;
  assign prod_o = prod_q;

endmodule

// File: src/ofa_add_tree.sv
module ofa_add_tree
  import ofa_pkg::*;
#(
  parameter int unsigned Levels = 5
) (
  input  logic                             clk_i,
  input  logic [Levels:1]                  adv_i,
  input  logic signed [PROD_W-1:0]         leaf_i [1 << Levels],
  output logic signed [PROD_W+Levels-1:0]  sum_o
);

  localparam int unsigned NumLeaves = 1 << Levels;
  localparam int unsigned AccW      = PROD_W + Levels;

  // Heap layout: node i adds entries 2i and 2i+1, leaves sit at NumLeaves and up
  logic signed [AccW-1:0] node_q   [1:NumLeaves-1];
  logic signed [AccW-1:0] tree_val [2:2*NumLeaves-1];

  // Pipeline stage of a node: leaves' parents are stage 1, the root is stage Levels
  function automatic int unsigned node_stage(input int unsigned idx);
    return Levels + 1 - $clog2(idx + 1);
  endfunction

  // Operand view over registered nodes and sign-extended leaves
  always_comb begin
    for (int i = 2; i < 2 * NumLeaves; i++) begin
      if (i < NumLeaves) begin
        tree_val[i] = node_q[i];
      end else begin
        tree_val[i] = AccW'(leaf_i[i - NumLeaves]);
      end
    end
  end

  // One registered add per node, each level moving with its own stage
  always_ff @(posedge clk_i) begin
    for (int i = 1; i < NumLeaves; i++) begin
      if (adv_i[node_stage(i)]) begin
        node_q[i] <= tree_val[2*i] + tree_val[2*i+1];
      end
    end
  end

  assign sum_o = node_q[1];

endmodule

// File: src/ofa_out_stage.sv
module ofa_out_stage
  import ofa_pkg::*;
#(
  parameter int unsigned AccW = PROD_W + 5
) (
  input  logic                    clk_i,
  input  logic                    load_i,
  input  logic signed [AccW-1:0]  sum_i,
  output logic signed [SMP_W-1:0] filtered_o,
  output logic                    saturated_o
);

  localparam int unsigned QW = AccW + 1 - FRAC_BITS;

  logic signed [AccW:0]     rnd;
  logic signed [QW-1:0]     quo;
  logic [QW-SMP_W:0]        top_bits;
  logic                     sat_d;
  logic signed [SMP_W-1:0]  filt_d;
  logic signed [SMP_W-1:0]  filt_q;
  logic                     sat_q;

  // Round half up, then floor shift
  assign rnd = (AccW+1)'(sum_i) + (AccW+1)'(ROUND_BIAS);
  assign quo = rnd[AccW:FRAC_BITS];

  // Out of range when the bits above the result do not all match its sign
  assign top_bits = quo[QW-1:SMP_W-1];
  assign sat_d    = !((&top_bits) || !(|top_bits));

  always_comb begin
    if (!sat_d) begin
      filt_d = quo[SMP_W-1:0];
    end else if (quo[QW-1]) begin
      filt_d = {1'b1, {(SMP_W-1){1'b0}}};
    end else begin
      filt_d = {1'b0, {(SMP_W-1){1'b1}}};
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      filt_q <= filt_d;
      sat_q  <= sat_d;
    end
  end

  assign filtered_o  = filt_q;
  assign saturated_o = sat_q;

endmodule
